>>> rtl/bfaq_pkg.sv
// bfaq_pkg: constants, types and helper functions of the bloom filter
// used by bfaq_ctrl, bfaq_dpath and bloom_filter_add_query
`default_nettype none
package bfaq_pkg;

    localparam int MAX_FILTER_BITS = 65536;
    localparam int MAX_PROBES      = 16;
    localparam int POS_W           = $clog2(MAX_FILTER_BITS);
    localparam int BC_W            = POS_W + 1;
    localparam int PC_W            = $clog2(MAX_PROBES) + 1;
    localparam int ROW_W           = 32;
    localparam int BIT_W           = $clog2(ROW_W);
    localparam int ROWS            = MAX_FILTER_BITS / ROW_W;
    localparam int ROW_AW          = $clog2(ROWS);
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = BC_W;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 1'd1;

    localparam logic [BC_W-1:0] BIT_COUNT_RESET   = BC_W'(MAX_FILTER_BITS);
    localparam logic [PC_W-1:0] PROBE_COUNT_RESET = PC_W'(7);

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2     = 32'h1b873593;
    localparam logic [31:0] MM_E      = 32'he6546b64;
    localparam logic [31:0] MM_F1     = 32'h85ebca6b;
    localparam logic [31:0] MM_F2     = 32'hc2b2ae35;
    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_TAKE,
        OP_CLR_ROW,
        OP_BLK_K1,
        OP_BLK_K2,
        OP_BLK_MIX,
        OP_FIN_A,
        OP_FIN_B,
        OP_FIN_C,
        OP_DIV_H1,
        OP_DIV_H2,
        OP_DIV_STEP,
        OP_SAVE_P,
        OP_SAVE_D,
        OP_PRB_RD,
        OP_PRB_CHK,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic blk_full;
        logic last_in;
        logic last_reg;
        logic clr_last;
        logic div_last;
        logic prb_done;
        logic out_full;
    } dp_stat_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] xsh(input logic [31:0] x, input int r);
        return x ^ (x >> r);
    endfunction

endpackage
`default_nettype wire

>>> rtl/bfaq_if.sv
// bfaq_req_if, bfaq_rsp_if: valid/ready channels of the bloom filter
// depends on no other file
`default_nettype none
interface bfaq_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] key_byte;
    logic       last_byte;
    logic       empty_key;

    modport source (output valid, func, key_byte, last_byte, empty_key, input ready);
    modport sink (input valid, func, key_byte, last_byte, empty_key, output ready);
endinterface

interface bfaq_rsp_if;
    logic valid;
    logic ready;
    logic may_contain;
    logic was_add;

    modport source (output valid, may_contain, was_add, input ready);
    modport sink (input valid, may_contain, was_add, output ready);
endinterface
`default_nettype wire

>>> rtl/bfaq_ctrl.sv
// bfaq_ctrl: sequencer of the bloom filter, issues one datapath command per cycle
// depends on bfaq_pkg
`default_nettype none
module bfaq_ctrl
    import bfaq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [18:0] {
        ST_IDLE = 19'd1,
        ST_CLR  = 19'd2,
        ST_K1   = 19'd4,
        ST_K2   = 19'd8,
        ST_KMIX = 19'd16,
        ST_FK1  = 19'd32,
        ST_FK2  = 19'd64,
        ST_FA   = 19'd128,
        ST_FB   = 19'd256,
        ST_FC   = 19'd512,
        ST_DV1  = 19'd1024,
        ST_DS1  = 19'd2048,
        ST_SV1  = 19'd4096,
        ST_DV2  = 19'd8192,
        ST_DS2  = 19'd16384,
        ST_SV2  = 19'd32768,
        ST_PRD  = 19'd65536,
        ST_PCHK = 19'd131072,
        ST_DONE = 19'd262144
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLR:
            begin
                cmd.op = OP_CLR_ROW;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = OP_TAKE;
                    if (stat.blk_full)
                    begin
                        state_next = ST_K1;
                    end
                    else if (stat.last_in)
                    begin
                        state_next = ST_FK1;
                    end
                end
            end
            ST_K1:
            begin
                cmd.op     = OP_BLK_K1;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                cmd.op     = OP_BLK_K2;
                state_next = ST_KMIX;
            end
            ST_KMIX:
            begin
                cmd.op     = OP_BLK_MIX;
                state_next = stat.last_reg ? ST_FK1 : ST_IDLE;
            end
            ST_FK1:
            begin
                cmd.op     = OP_BLK_K1;
                state_next = ST_FK2;
            end
            ST_FK2:
            begin
                cmd.op     = OP_BLK_K2;
                state_next = ST_FA;
            end
            ST_FA:
            begin
                cmd.op     = OP_FIN_A;
                state_next = ST_FB;
            end
            ST_FB:
            begin
                cmd.op     = OP_FIN_B;
                state_next = ST_FC;
            end
            ST_FC:
            begin
                cmd.op     = OP_FIN_C;
                state_next = ST_DV1;
            end
            ST_DV1:
            begin
                cmd.op     = OP_DIV_H1;
                state_next = ST_DS1;
            end
            ST_DS1:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = ST_SV1;
                end
            end
            ST_SV1:
            begin
                cmd.op     = OP_SAVE_P;
                state_next = ST_DV2;
            end
            ST_DV2:
            begin
                cmd.op     = OP_DIV_H2;
                state_next = ST_DS2;
            end
            ST_DS2:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = ST_SV2;
                end
            end
            ST_SV2:
            begin
                cmd.op     = OP_SAVE_D;
                state_next = ST_PRD;
            end
            ST_PRD:
            begin
                if (stat.prb_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_PRB_RD;
                    state_next = ST_PCHK;
                end
            end
            ST_PCHK:
            begin
                cmd.op     = OP_PRB_CHK;
                state_next = ST_PRD;
            end
            ST_DONE:
            begin
                if (!stat.out_full)
                begin
                    cmd.op     = OP_DONE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/bfaq_dpath.sv
// bfaq_dpath: config registers, hash registers, remainder unit, probe logic, bit store and result register
// depends on bfaq_pkg
`default_nettype none
module bfaq_dpath
    import bfaq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_func,
    input  wire logic [7:0]            in_key_byte,
    input  wire logic                  in_last_byte,
    input  wire logic                  in_empty_key,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       out_may_contain,
    output logic                       out_was_add
);

    logic [BC_W-1:0]   bit_count_reg;
    logic [PC_W-1:0]   probe_count_reg;
    logic [31:0]       macc_reg, macc_next;
    logic [31:0]       fnv_reg, fnv_next;
    logic [31:0]       blk_reg, blk_next;
    logic [31:0]       len_reg, len_next;
    logic [31:0]       tmp_reg, tmp_next;
    logic [31:0]       dvd_reg, dvd_next;
    logic [BC_W-1:0]   rem_reg, rem_next;
    logic [4:0]        div_cnt_reg, div_cnt_next;
    logic [POS_W-1:0]  p_reg, p_next;
    logic [POS_W-1:0]  d_reg, d_next;
    logic [PC_W-1:0]   prb_cnt_reg, prb_cnt_next;
    logic              hit_reg, hit_next;
    logic              func_reg, last_reg;
    logic [ROW_AW-1:0] clr_cnt_reg;
    logic              out_valid_reg, out_valid_next;
    logic              may_reg, was_add_reg;
    logic [ROW_W-1:0]  rd_data_reg;
    logic [ROW_W-1:0]  mem [ROWS];

    logic [BC_W-1:0]   m_eff;
    logic [PC_W-1:0]   pc_eff;
    logic [BC_W:0]     rem_try;
    logic [BC_W:0]     p_sum;
    logic [31:0]       fin_h;
    logic [31:0]       b32;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic              cur_bit;

    always_comb
    begin
        if (bit_count_reg == '0)
        begin
            m_eff = BC_W'(1);
        end
        else if (bit_count_reg > BC_W'(MAX_FILTER_BITS))
        begin
            m_eff = BC_W'(MAX_FILTER_BITS);
        end
        else
        begin
            m_eff = bit_count_reg;
        end
        pc_eff = (probe_count_reg > PC_W'(MAX_PROBES)) ? PC_W'(MAX_PROBES) : probe_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg   <= BIT_COUNT_RESET;
            probe_count_reg <= PROBE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_BIT_COUNT:   bit_count_reg   <= cfg_data;
                REG_PROBE_COUNT: probe_count_reg <= cfg_data[PC_W-1:0];
                default:         ;
            endcase
        end
    end

    assign b32     = {24'd0, in_key_byte};
    assign rem_try = {rem_reg, dvd_reg[31]};
    assign p_sum   = BC_W'(p_reg) + BC_W'(d_reg);
    assign fin_h   = xsh(macc_reg ^ ((len_reg[1:0] != 2'd0) ? tmp_reg : 32'd0) ^ len_reg, 16);
    assign cur_bit = rd_data_reg[p_reg[BIT_W-1:0]];

    always_comb
    begin
        macc_next      = macc_reg;
        fnv_next       = fnv_reg;
        blk_next       = blk_reg;
        len_next       = len_reg;
        tmp_next       = tmp_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        p_next         = p_reg;
        d_next         = d_reg;
        prb_cnt_next   = prb_cnt_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_waddr      = p_reg[POS_W-1:BIT_W];
        mem_wdata      = rd_data_reg | (ROW_W'(1) << p_reg[BIT_W-1:0]);
        case (cmd.op)
            OP_TAKE:
            begin
                if (!in_empty_key)
                begin
                    fnv_next = (fnv_reg ^ b32) * FNV_PRIME;
                    blk_next = blk_reg | (b32 << {len_reg[1:0], 3'd0});
                    len_next = len_reg + 32'd1;
                end
            end
            OP_CLR_ROW:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            OP_BLK_K1:   tmp_next = blk_reg * MM_C1;
            OP_BLK_K2:   tmp_next = rotl32(tmp_reg, 15) * MM_C2;
            OP_BLK_MIX:
            begin
                macc_next = (rotl32(macc_reg ^ tmp_reg, 13) * 32'd5) + MM_E;
                blk_next  = '0;
            end
            OP_FIN_A:    tmp_next = fin_h * MM_F1;
            OP_FIN_B:    tmp_next = xsh(tmp_reg, 13) * MM_F2;
            OP_FIN_C:    tmp_next = xsh(tmp_reg, 16);
            OP_DIV_H1:
            begin
                dvd_next     = tmp_reg;
                rem_next     = '0;
                div_cnt_next = '0;
            end
            OP_DIV_H2:
            begin
                dvd_next     = fnv_reg;
                rem_next     = '0;
                div_cnt_next = '0;
            end
            OP_DIV_STEP:
            begin
                rem_next     = (rem_try >= {1'b0, m_eff}) ? BC_W'(rem_try - {1'b0, m_eff})
                                                          : rem_try[BC_W-1:0];
                dvd_next     = dvd_reg << 1;
                div_cnt_next = div_cnt_reg + 5'd1;
            end
            OP_SAVE_P:   p_next = rem_reg[POS_W-1:0];
            OP_SAVE_D:
            begin
                d_next       = rem_reg[POS_W-1:0];
                prb_cnt_next = '0;
                hit_next     = 1'b1;
            end
            OP_PRB_CHK:
            begin
                if (func_reg == FUNC_ADD)
                begin
                    mem_we = 1'b1;
                end
                else if (!cur_bit)
                begin
                    hit_next = 1'b0;
                end
                p_next       = (p_sum >= {1'b0, m_eff}) ? POS_W'(p_sum - {1'b0, m_eff})
                                                        : p_sum[POS_W-1:0];
                prb_cnt_next = prb_cnt_reg + PC_W'(1);
            end
            OP_DONE:
            begin
                out_valid_next = 1'b1;
                macc_next      = '0;
                fnv_next       = FNV_BASIS;
                blk_next       = '0;
                len_next       = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            macc_reg      <= '0;
            fnv_reg       <= FNV_BASIS;
            blk_reg       <= '0;
            len_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            macc_reg      <= macc_next;
            fnv_reg       <= fnv_next;
            blk_reg       <= blk_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            if (cmd.op == OP_CLR_ROW)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_AW'(1);
            end
            if (cmd.op == OP_TAKE)
            begin
                last_reg <= in_last_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg     <= tmp_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        p_reg       <= p_next;
        d_reg       <= d_next;
        prb_cnt_reg <= prb_cnt_next;
        hit_reg     <= hit_next;
        if (cmd.op == OP_TAKE)
        begin
            func_reg <= in_func;
        end
        if (cmd.op == OP_DONE)
        begin
            may_reg     <= (func_reg == FUNC_QUERY) && hit_reg;
            was_add_reg <= (func_reg == FUNC_ADD);
        end
    end

    // bit store, one row per address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PRB_RD)
        begin
            rd_data_reg <= mem[p_reg[POS_W-1:BIT_W]];
        end
    end

    assign stat.blk_full = !in_empty_key && (len_reg[1:0] == 2'd3);
    assign stat.last_in  = in_last_byte;
    assign stat.last_reg = last_reg;
    assign stat.clr_last = (clr_cnt_reg == ROW_AW'(ROWS - 1));
    assign stat.div_last = (div_cnt_reg == 5'd31);
    assign stat.prb_done = (prb_cnt_reg == pc_eff);
    assign stat.out_full = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign out_may_contain = may_reg;
    assign out_was_add     = was_add_reg;

endmodule
`default_nettype wire

>>> rtl/bloom_filter_add_query.sv
// bloom_filter_add_query: top level, joins controller and datapath to the channels
// depends on bfaq_pkg, bfaq_if, bfaq_ctrl, bfaq_dpath
//
//  channel  dir  signals                                     word accepted when
//  req      in   func key_byte last_byte empty_key           valid && ready
//  rsp      out  may_contain was_add                         valid && ready
//  cfg      in   cfg_we cfg_idx cfg_data                     cfg_we high
//
// a key byte is taken in ST_IDLE; one that completes a 4-byte murmur block then runs K1, K2 and KMIX
// the last byte adds finalization (FK1, FK2, FA, FB, FC), two bit-serial remainders
// and a read and a check per probe through the bit store, then ST_DONE issues the result
// after reset a clearing pass over all 2048 rows zeroes the store, req is not ready meanwhile
// a result waits in its register while the next key streams in
`default_nettype none
module bloom_filter_add_query
    import bfaq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bfaq_req_if.sink                   req,
    bfaq_rsp_if.source                 rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bfaq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfaq_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .in_func         (req.func),
        .in_key_byte     (req.key_byte),
        .in_last_byte    (req.last_byte),
        .in_empty_key    (req.empty_key),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_may_contain (rsp.may_contain),
        .out_was_add     (rsp.was_add)
    );

endmodule
`default_nettype wire

>>> bench/tb.sv
// tb: self-checking bench for bloom_filter_add_query, keys streamed over the req channel
// predicts each result with its own murmur3/fnv-1a bloom filter and checks the rsp channel
// depends on bfaq_pkg, bfaq_if and the bloom_filter_add_query rtl
module tb;
    import bfaq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 300;

    typedef logic [7:0] key_t[$];

    typedef struct {
        logic may_contain;
        logic was_add;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bfaq_req_if req ();
    bfaq_rsp_if rsp ();

    bloom_filter_add_query u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // predicted filter state
    bit          filter_mem [MAX_FILTER_BITS];
    bit [31:0]   mm_acc;
    bit [31:0]   fnv_acc;
    bit [31:0]   blk_word;
    bit [31:0]   key_len;
    bit [16:0]   bits_used;
    bit [4:0]    probes_used;

    answer_t     answer_q[$];
    key_t        added_keys[$];
    int          fail_count;
    int          cycle_count;
    int          words_sent;
    bit          idle_on;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit [31:0] rot_left(bit [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic bit [31:0] mm_scramble(bit [31:0] k);
        bit [31:0] v;
        v = k * 32'hcc9e2d51;
        v = rot_left(v, 15);
        return v * 32'h1b873593;
    endfunction

    function automatic void reset_hashes();
        mm_acc = 32'd0;
        fnv_acc = 32'h811c9dc5;
        blk_word = 32'd0;
        key_len = 32'd0;
    endfunction

    function automatic void absorb_byte(bit [7:0] b);
        fnv_acc = (fnv_acc ^ {24'd0, b}) * 32'h01000193;
        blk_word = blk_word | ({24'd0, b} << (8 * key_len[1:0]));
        key_len = key_len + 1;
        if (key_len[1:0] == 2'd0)
        begin
            mm_acc = rot_left(mm_acc ^ mm_scramble(blk_word), 13);
            mm_acc = mm_acc * 5 + 32'he6546b64;
            blk_word = 32'd0;
        end
    endfunction

    function automatic bit [31:0] murmur_result();
        bit [31:0] h;
        h = mm_acc;
        if (key_len[1:0] != 2'd0)
            h = h ^ mm_scramble(blk_word);
        h = h ^ key_len;
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic void predict_word(logic fn, logic [7:0] kb, logic lb, logic ek);
        longint unsigned h1;
        longint unsigned h2;
        longint unsigned m;
        longint unsigned pos;
        int n;
        bit hit;
        answer_t a;
        hit = 1'b1;
        if (!ek)
            absorb_byte(kb);
        if (!lb)
            return;
        h1 = murmur_result();
        h2 = fnv_acc;
        m = bits_used;
        if (m == 0)
            m = 1;
        if (m > MAX_FILTER_BITS)
            m = MAX_FILTER_BITS;
        n = (probes_used > MAX_PROBES) ? MAX_PROBES : probes_used;
        for (int i = 0; i < n; i++)
        begin
            pos = (h1 + longint'(i) * h2) % m;
            if (fn == FUNC_ADD)
                filter_mem[pos] = 1'b1;
            else if (!filter_mem[pos])
                hit = 1'b0;
        end
        a.may_contain = (fn == FUNC_QUERY) && hit;
        a.was_add = (fn == FUNC_ADD);
        answer_q.push_back(a);
        reset_hashes();
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result check
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answer_q.size() == 0)
            begin
                $error("unexpected result word may_contain=%0b was_add=%0b",
                       rsp.may_contain, rsp.was_add);
                fail_count++;
            end
            else
            begin
                e = answer_q.pop_front();
                if (rsp.may_contain !== e.may_contain)
                begin
                    $error("may_contain expected %0b actual %0b", e.may_contain, rsp.may_contain);
                    fail_count++;
                end
                if (rsp.was_add !== e.was_add)
                begin
                    $error("was_add expected %0b actual %0b", e.was_add, rsp.was_add);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp.ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            else
            begin
                rsp.ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    task automatic send_word(logic fn, logic [7:0] kb, logic lb, logic ek);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        req.func = fn;
        req.key_byte = kb;
        req.last_byte = lb;
        req.empty_key = ek;
        req.valid = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        predict_word(fn, kb, lb, ek);
        if (!(ek && !lb))
            words_sent++;
        @(negedge clk);
    endtask

    // key ends either on its last byte or on a trailing empty word
    task automatic send_key(logic fn, key_t k, bit trailing_empty);
        for (int i = 0; i < k.size(); i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b1);
            if (i == k.size() - 1 && !trailing_empty)
                send_word(fn, k[i], 1'b1, 1'b0);
            else
                send_word(1'($urandom_range(0, 1)), k[i], 1'b0, 1'b0);
        end
        if (k.size() == 0 || trailing_empty)
            send_word(fn, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
        if (fn == FUNC_ADD)
            added_keys.push_back(k);
    endtask

    function automatic key_t random_key(int len);
        key_t k;
        for (int i = 0; i < len; i++)
            k.push_back(8'($urandom_range(0, 255)));
        return k;
    endfunction

    task automatic drain();
        req.valid = 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_BIT_COUNT)
            bits_used = val;
        else
            probes_used = val[4:0];
    endtask

    task automatic set_filter(int bc, int pc);
        drain();
        write_reg(REG_BIT_COUNT, CFG_DATA_W'(bc));
        write_reg(REG_PROBE_COUNT, CFG_DATA_W'(pc));
    endtask

    task automatic test_directed_keys();
        key_t k;
        send_key(FUNC_QUERY, k, 1'b0);
        send_key(FUNC_ADD, k, 1'b0);
        send_key(FUNC_QUERY, k, 1'b0);
        k = '{8'h00};
        send_key(FUNC_ADD, k, 1'b0);
        k = '{8'hff, 8'hff};
        send_key(FUNC_ADD, k, 1'b0);
        k = '{8'h00, 8'hff, 8'h5a};
        send_key(FUNC_ADD, k, 1'b1);
        k = '{8'hff, 8'h00, 8'hff, 8'h00};
        send_key(FUNC_ADD, k, 1'b0);
        send_key(FUNC_QUERY, k, 1'b0);
        k = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        send_key(FUNC_QUERY, k, 1'b0);
        send_word(FUNC_ADD, 8'hff, 1'b0, 1'b1);
        send_word(FUNC_QUERY, 8'h00, 1'b0, 1'b1);
        k = '{8'h00, 8'hff, 8'h5a};
        send_key(FUNC_QUERY, k, 1'b0);
    endtask

    task automatic test_config_extremes();
        key_t k;
        int cfgs[6][2] = '{'{0, 0}, '{1, 1}, '{131071, 31}, '{65536, 16}, '{8, 17}, '{65535, 0}};
        foreach (cfgs[c])
        begin
            set_filter(cfgs[c][0], cfgs[c][1]);
            for (int j = 0; j < 3; j++)
            begin
                k = random_key($urandom_range(0, 6));
                send_key(FUNC_ADD, k, 1'b0);
                send_key(FUNC_QUERY, k, 1'($urandom_range(0, 1)));
                send_key(FUNC_QUERY, random_key($urandom_range(1, 6)), 1'b0);
            end
        end
    endtask

    task automatic test_random_traffic(int target);
        key_t k;
        int sel;
        int stop_at;
        stop_at = words_sent + target;
        while (words_sent < stop_at)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4 || added_keys.size() == 0)
            begin
                if ($urandom_range(0, 19) == 0)
                    k = random_key($urandom_range(20, 40));
                else
                    k = random_key($urandom_range(0, 8));
                send_key(FUNC_ADD, k, $urandom_range(0, 3) == 0);
            end
            else if (sel < 8)
                send_key(FUNC_QUERY, added_keys[$urandom_range(0, added_keys.size() - 1)],
                         $urandom_range(0, 3) == 0);
            else
                send_key(FUNC_QUERY, random_key($urandom_range(0, 8)), 1'b0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.func = FUNC_ADD;
        req.key_byte = 8'd0;
        req.last_byte = 1'b0;
        req.empty_key = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        words_sent = 0;
        idle_on = 1'b1;
        bits_used = BIT_COUNT_RESET;
        probes_used = PROBE_COUNT_RESET;
        reset_hashes();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed_keys();
        test_config_extremes();
        set_filter(65536, 7);
        test_random_traffic(150);
        set_filter(512, 4);
        test_random_traffic(150);
        set_filter(37, 2);
        test_random_traffic(100);
        set_filter(4096, 16);
        idle_on = 1'b0;
        test_random_traffic(150);
        drain();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> files.f
rtl/bfaq_pkg.sv
rtl/bfaq_if.sv
rtl/bfaq_ctrl.sv
rtl/bfaq_dpath.sv
rtl/bloom_filter_add_query.sv
bench/tb.sv
